FILE: rtl/ksr_pkg.sv
// ----------------------------------------------------------------------------
// ksr_pkg
// Shared constants and the types passed between controller and datapath.
// ----------------------------------------------------------------------------
package ksr_pkg;

  localparam int MAX_GROUP_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int CFG_W          = 5;
  // widest store address over the supported MAX_GROUP range (up to 64)
  localparam int ADDR_W_MAX     = 6;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W_MAX-1:0] wr_addr;
    logic                  rd_en;
    logic [ADDR_W_MAX-1:0] rd_addr;
    logic                  rd_last;
  } ksr_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ksr_stat_t;

endpackage

FILE: rtl/ksr_datapath.sv
// ----------------------------------------------------------------------------
// ksr_datapath
// Group store memory and the registered output stage.
// ----------------------------------------------------------------------------
module ksr_datapath import ksr_pkg::*; #(
  parameter int MAX_GROUP  = MAX_GROUP_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ksr_cmd_t                     cmd,
  output ksr_stat_t                    stat,
  input  logic signed [WORD_WIDTH-1:0] data_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] data_out,
  output logic                         last_out
);

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [WORD_WIDTH-1:0] mem [MAX_GROUP];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[IDX_W-1:0]] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      data_out <= mem[cmd.rd_addr[IDX_W-1:0]];
      last_out <= cmd.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

FILE: rtl/ksr_ctrl.sv
// ----------------------------------------------------------------------------
// ksr_ctrl
// Collect/emit sequencer, fill count and group size register.
// ----------------------------------------------------------------------------
module ksr_ctrl import ksr_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             end_of_list,
  input  logic             group_size_we,
  input  logic [CFG_W-1:0] group_size,
  input  ksr_stat_t        stat,
  output ksr_cmd_t         cmd
);

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    S_COLLECT = 2'b01,
    S_EMIT    = 2'b10
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] fill;
  logic [CNT_W-1:0] gsize;
  logic [CNT_W-1:0] remain;
  logic [IDX_W-1:0] addr;
  logic             rev;
  logic             endf;

  logic [CNT_W-1:0] n;
  logic             accept;
  logic             rd_go;
  logic             full;
  logic [CMP_W-1:0] wval;
  logic [CMP_W-1:0] gsize_next;

  always_comb begin
    in_ready = (state == S_COLLECT);
    accept   = in_valid && in_ready;
    n        = CNT_W'(fill) + CNT_W'(1);
    full     = (n >= gsize);
    rd_go    = (state == S_EMIT) && !stat.out_busy;

    cmd         = '0;
    cmd.wr_en   = accept;
    cmd.wr_addr = ADDR_W_MAX'(fill);
    cmd.rd_en   = rd_go;
    cmd.rd_addr = ADDR_W_MAX'(addr);
    cmd.rd_last = endf && (remain == CNT_W'(1));
  end

  always_comb begin
    wval = CMP_W'(group_size);
    if (wval == '0) begin
      gsize_next = CMP_W'(1);
    end else if (wval > CMP_W'(MAX_GROUP)) begin
      gsize_next = CMP_W'(MAX_GROUP);
    end else begin
      gsize_next = wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gsize <= CNT_W'(1);
    end else if (group_size_we) begin
      gsize <= CNT_W'(gsize_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_COLLECT;
      fill   <= '0;
      remain <= '0;
      addr   <= '0;
      rev    <= 1'b0;
      endf   <= 1'b0;
    end else begin
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            if (full || end_of_list) begin
              state  <= S_EMIT;
              remain <= n;
              rev    <= full;
              endf   <= end_of_list;
              addr   <= full ? fill : '0;
              fill   <= '0;
            end else begin
              fill <= IDX_W'(n);
            end
          end
        end
        S_EMIT: begin
          if (rd_go) begin
            remain <= remain - CNT_W'(1);
            addr   <= rev ? addr - IDX_W'(1) : addr + IDX_W'(1);
            if (remain == CNT_W'(1)) begin
              state <= S_COLLECT;
            end
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

endmodule

FILE: rtl/k_group_stream_reverser.sv
// ----------------------------------------------------------------------------
// k_group_stream_reverser
// Buffers list words into groups of group_size and emits each full group
// newest first; a partial group at the end of a list goes out in order.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    data_in, end_of_list
//   out       output     out_valid / out_ready  data_out, last_out
//   config    input      group_size_we          group_size
//
// Words are taken one a cycle until a group closes; then the group store is
// read out one word a cycle, unless the output stalls, through a single read
// port. The last word of a group may wait in the output register while input
// resumes. Output stalls hold the read sequence. Reset (rst, synchronous)
// empties the group and sets group_size to 1; the store is not cleared.
// ----------------------------------------------------------------------------
module k_group_stream_reverser import ksr_pkg::*; #(
  parameter int MAX_GROUP  = MAX_GROUP_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [WORD_WIDTH-1:0] data_in,
  input  logic                         end_of_list,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] data_out,
  output logic                         last_out,
  input  logic                         group_size_we,
  input  logic [CFG_W-1:0]             group_size
);

  ksr_cmd_t  cmd;
  ksr_stat_t stat;

  ksr_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .end_of_list   (end_of_list),
    .group_size_we (group_size_we),
    .group_size    (group_size),
    .stat          (stat),
    .cmd           (cmd)
  );

  ksr_datapath #(
    .MAX_GROUP  (MAX_GROUP),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .last_out  (last_out)
  );

endmodule

FILE: rtl/ksr_checker.sv
// ----------------------------------------------------------------------------
// ksr_checker
// Port-level checks for the group reverser, bound to the top level.
// ----------------------------------------------------------------------------
module ksr_checker import ksr_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         end_of_list,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [WORD_WIDTH-1:0] data_out,
  input logic                         last_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last_out))
    else $error("output transaction changed while stalled");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_list |=> !in_ready)
    else $error("end of list did not start an emit phase");

  a_out_after_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output appeared while collecting");

endmodule

bind k_group_stream_reverser ksr_checker #(
  .WORD_WIDTH (WORD_WIDTH)
) u_ksr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .end_of_list (end_of_list),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .data_out    (data_out),
  .last_out    (last_out)
);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_group_stream_reverser. A queue of list words
// feeds a bursty driver; an internal predictor reorders each accepted word
// into the expected output words, and a monitor compares every output
// transaction against them. Group size is rewritten between phases after the
// queues drain, covering zero, saturating, shrinking and full-range values.
// ----------------------------------------------------------------------------
module tb;
  import ksr_pkg::*;

  typedef struct {
    logic signed [WORD_WIDTH_DEF-1:0] word;
    logic                             eol;
  } list_word_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic signed [WORD_WIDTH_DEF-1:0] data_in = '0;
  logic                             end_of_list = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [WORD_WIDTH_DEF-1:0] data_out;
  logic                             last_out;
  logic                             group_size_we = 1'b0;
  logic [CFG_W-1:0]                 group_size = '0;

  list_word_t pend_q[$];
  list_word_t out_words_q[$];

  logic signed [WORD_WIDTH_DEF-1:0] held_words[MAX_GROUP_DEF];
  int held_cnt = 0;
  int grp_len = 1;

  logic in_took = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  logic [15:0] stall_pat = 16'hffff;
  int   pat_pos = 0;
  int   err_cnt = 0;

  k_group_stream_reverser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_in      (data_in),
    .end_of_list  (end_of_list),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_out     (data_out),
    .last_out     (last_out),
    .group_size_we(group_size_we),
    .group_size   (group_size)
  );

  always #10 clk = ~clk;

  function automatic int clamp_group_size(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_GROUP_DEF) return MAX_GROUP_DEF;
    return v;
  endfunction

  task automatic reverse_group_step(input logic signed [WORD_WIDTH_DEF-1:0] w,
                                    input logic eol);
    int n;
    list_word_t r;
    if (held_cnt < MAX_GROUP_DEF) begin
      held_words[held_cnt] = w;
      held_cnt++;
    end
    n = held_cnt;
    if (n >= grp_len) begin
      for (int i = 0; i < n; i++) begin
        r.word = held_words[n - 1 - i];
        r.eol  = eol && (i == n - 1);
        out_words_q.push_back(r);
      end
      held_cnt = 0;
    end else if (eol) begin
      for (int i = 0; i < n; i++) begin
        r.word = held_words[i];
        r.eol  = (i == n - 1);
        out_words_q.push_back(r);
      end
      held_cnt = 0;
    end
  endtask

  task automatic report_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // accept input transactions
  always @(posedge clk) begin
    in_took <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) reverse_group_step(data_in, end_of_list);
  end

  always @(negedge clk) begin : feed
    list_word_t nxt;
    logic       drive;
    if (!(in_valid && !in_took)) begin
      drive = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_q.size() != 0) begin
        nxt = pend_q.pop_front();
        data_in     <= nxt.word;
        end_of_list <= nxt.eol;
        drive = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(20, 40);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
      in_valid <= drive;
    end
  end

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (pat_pos == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hffff;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
      end
      out_ready <= stall_pat[pat_pos];
      pat_pos = (pat_pos + 1) % 16;
    end
  end

  always @(posedge clk) begin : check_out
    list_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (out_words_q.size() == 0) begin
        report_err($sformatf("unexpected output data=%0d last=%0b", data_out, last_out));
      end else begin
        want = out_words_q.pop_front();
        if (data_out !== want.word || last_out !== want.eol)
          report_err($sformatf("expected data=%0d last=%0b, got data=%0d last=%0b",
                               want.word, want.eol, data_out, last_out));
      end
    end
  end

  task automatic write_group_size(input logic [CFG_W-1:0] v);
    @(negedge clk);
    group_size_we <= 1'b1;
    group_size    <= v;
    @(negedge clk);
    group_size_we <= 1'b0;
    grp_len = clamp_group_size(v);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pend_q.size() != 0 || in_valid || out_words_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic queue_word(input logic signed [WORD_WIDTH_DEF-1:0] w, input logic eol);
    list_word_t it;
    it.word = w;
    it.eol  = eol;
    pend_q.push_back(it);
  endtask

  function automatic logic signed [WORD_WIDTH_DEF-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_list(input int len, input logic close);
    for (int i = 0; i < len; i++) queue_word(pick_word(), close && (i == len - 1));
  endtask

  initial begin
    int sent;
    int len;
    int sel;
    logic [CFG_W-1:0] gsv;
    logic paused;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // group size 1 out of reset
    queue_word(32'sh7fff_ffff, 1'b0);
    queue_word(32'sh8000_0000, 1'b1);
    queue_word(-32'sd1, 1'b0);
    wait_idle();
    write_group_size(5'd0);
    queue_word(32'sd0, 1'b1);
    wait_idle();
    // saturate to the largest group, full group closing the list
    write_group_size(5'd31);
    for (int i = 0; i < MAX_GROUP_DEF; i++) queue_word(i + 1, i == MAX_GROUP_DEF - 1);
    wait_idle();
    // partial tail in arrival order
    write_group_size(5'd4);
    queue_word(32'sd100, 1'b0);
    queue_word(-32'sd200, 1'b1);
    wait_idle();
    // shrink while words are held
    queue_list(3, 1'b0);
    wait_idle();
    write_group_size(5'd2);
    queue_word(32'sd7, 1'b1);
    wait_idle();

    paused = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) gsv = 5'd0;
      else if (sel == 1) gsv = CFG_W'($urandom_range(17, 31));
      else if (sel == 2) gsv = 5'd16;
      else gsv = CFG_W'($urandom_range(1, 16));
      write_group_size(gsv);
      if (ph == 2) hold_reqs++;
      sent = 0;
      while (sent < 40) begin
        len = $urandom_range(1, 2 * grp_len + 3);
        queue_list(len, $urandom_range(0, 7) != 0);
        sent += len;
        if (ph == 5 && !paused && sent >= 20) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && out_words_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
